// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the checker file of the key debounce block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_CLKD(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/kdef_pkg.sv -----
// ----------------------------------------------------------------------------
// kdef_pkg
// Types and constants of the key debounce and event FIFO block.
// ----------------------------------------------------------------------------
package kdef_pkg;

    // Fixed field widths.
    localparam int KEY_W    = 3;
    localparam int LEVELS_W = 8;
    localparam int TICKS_W  = 10;
    localparam int EVENT_W  = 4;

    // Debounce delay after reset.
    localparam logic [TICKS_W-1:0] DEBOUNCE_RESET = 10'd20;

    // Request operation codes.
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_EDGE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // Commands from the sequencer to the countdown bank.
    typedef struct packed {
        logic load;
        logic step;
    } timer_cmd_t;

endpackage

// ----- rtl/core/key_debounce_event_fifo_core.sv -----
// ----------------------------------------------------------------------------
// key_debounce_event_fifo_core
// Sequence: an edge, a read or an unused code passes from idle through the
// execute and finish states; a tick also scans the countdowns between them,
// visiting one key per cycle through the shared decrement and compare unit.
// Throughput: one request at a time; in_ready rises once the result is loaded.
// Reset: countdowns, armed flags and FIFO pointers clear, delay returns to 20;
// event storage is not cleared.
// ----------------------------------------------------------------------------
module key_debounce_event_fifo_core #(
    parameter int NUM_KEYS   = 8,
    parameter int FIFO_DEPTH = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     operation,
    input  logic [kdef_pkg::KEY_W-1:0]     key_number,
    input  logic [kdef_pkg::LEVELS_W-1:0]  key_levels,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           read_valid,
    output logic [kdef_pkg::KEY_W-1:0]     read_key,
    output logic                           read_level,
    output logic                           fifo_empty,
    input  logic                           cfg_we,
    input  logic [kdef_pkg::TICKS_W-1:0]   cfg_wdata
);

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    kdef_pkg::state_t                 state_reg, state_next;
    logic [kdef_pkg::TICKS_W-1:0]     debounce_reg;
    logic [1:0]                       op_reg;
    logic [kdef_pkg::KEY_W-1:0]       key_reg;
    logic [kdef_pkg::LEVELS_W-1:0]    levels_reg;
    logic [KW-1:0]                    scan_reg, scan_next;
    logic [PW-1:0]                    rp_reg, rp_next;
    logic [PW-1:0]                    wp_reg, wp_next;
    logic                             hit_reg, hit_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             rd_valid_reg;
    logic [kdef_pkg::KEY_W-1:0]       rd_key_reg;
    logic                             rd_level_reg;
    logic                             empty_reg;

    kdef_pkg::timer_cmd_t             tcmd;
    logic [KW-1:0]                    timer_idx;
    logic                             fire;
    logic [31:0]                      key_ext;
    logic [31:0]                      scan_ext;
    logic                             key_in_range;
    logic                             level_bit;
    logic [PW-1:0]                    wp_inc;
    logic [PW-1:0]                    rp_inc;
    logic                             is_empty;
    logic                             is_full;
    logic                             push;
    logic                             pop;
    logic [kdef_pkg::EVENT_W-1:0]     push_data;
    logic [kdef_pkg::EVENT_W-1:0]     pop_data;
    logic                             slot_free;

    // Debounce delay register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= kdef_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            debounce_reg <= cfg_wdata;
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg     <= operation;
            key_reg    <= key_number;
            levels_reg <= key_levels;
        end
    end

    // FIFO pointer arithmetic; the ring wraps at FIFO_DEPTH.
    assign wp_inc   = (wp_reg == PW'(FIFO_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc   = (rp_reg == PW'(FIFO_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign is_empty = (rp_reg == wp_reg);
    assign is_full  = (wp_inc == rp_reg);

    // Key index checks and level sampling for the key under scan.
    assign key_ext      = 32'(key_reg);
    assign key_in_range = (key_ext < NUM_KEYS);
    assign scan_ext     = 32'(scan_reg);
    assign level_bit    = (scan_ext < kdef_pkg::LEVELS_W) ? levels_reg[scan_ext[2:0]] : 1'b0;
    assign push_data    = {scan_ext[kdef_pkg::KEY_W-1:0], level_bit};

    // Output slot is free when empty or being drained this cycle.
    assign slot_free = !out_valid_reg || out_ready;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        hit_next   = hit_reg;
        tcmd       = '0;
        timer_idx  = scan_reg;
        push       = 1'b0;
        pop        = 1'b0;

        unique case (state_reg)
            kdef_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = kdef_pkg::ST_EXEC;
                end
            end
            kdef_pkg::ST_EXEC:
            begin
                hit_next   = 1'b0;
                state_next = kdef_pkg::ST_FINISH;
                unique case (op_reg)
                    kdef_pkg::OP_TICK:
                    begin
                        scan_next  = '0;
                        state_next = kdef_pkg::ST_SCAN;
                    end
                    kdef_pkg::OP_EDGE:
                    begin
                        timer_idx = key_ext[KW-1:0];
                        tcmd.load = key_in_range;
                    end
                    kdef_pkg::OP_READ:
                    begin
                        if (!is_empty)
                        begin
                            pop      = 1'b1;
                            hit_next = 1'b1;
                            rp_next  = rp_inc;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            kdef_pkg::ST_SCAN:
            begin
                tcmd.step = 1'b1;
                if (fire && !is_full)
                begin
                    push    = 1'b1;
                    wp_next = wp_inc;
                end
                if (scan_reg == KW'(NUM_KEYS - 1))
                begin
                    state_next = kdef_pkg::ST_FINISH;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            kdef_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = kdef_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kdef_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register next state.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == kdef_pkg::ST_FINISH) && slot_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kdef_pkg::ST_IDLE;
            scan_reg      <= '0;
            rp_reg        <= '0;
            wp_reg        <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded when the sequencer finishes a request.
    always_ff @(posedge clk)
    begin
        if ((state_reg == kdef_pkg::ST_FINISH) && slot_free)
        begin
            rd_valid_reg <= hit_reg;
            rd_key_reg   <= hit_reg ? pop_data[kdef_pkg::EVENT_W-1:1] : '0;
            rd_level_reg <= hit_reg ? pop_data[0] : 1'b0;
            empty_reg    <= is_empty;
        end
    end

    // Countdown bank with its shared decrement unit.
    kdef_timer_bank #(
        .NUM_KEYS (NUM_KEYS)
    ) u_timers (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (tcmd),
        .idx        (timer_idx),
        .load_value (debounce_reg),
        .fire       (fire)
    );

    // Event storage.
    kdef_ram #(
        .WIDTH (kdef_pkg::EVENT_W),
        .DEPTH (FIFO_DEPTH)
    ) u_events (
        .clk   (clk),
        .we    (push),
        .waddr (wp_reg),
        .wdata (push_data),
        .re    (pop),
        .raddr (rp_reg),
        .rdata (pop_data)
    );

    assign in_ready   = (state_reg == kdef_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign read_valid = rd_valid_reg;
    assign read_key   = rd_key_reg;
    assign read_level = rd_level_reg;
    assign fifo_empty = empty_reg;

endmodule

// ----- rtl/core/kdef_ram.sv -----
// ----------------------------------------------------------------------------
// kdef_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kdef_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/kdef_timer_bank.sv -----
// ----------------------------------------------------------------------------
// kdef_timer_bank
// Per-key debounce countdowns with one shared decrement and compare unit.
// ----------------------------------------------------------------------------
module kdef_timer_bank #(
    parameter int NUM_KEYS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  kdef_pkg::timer_cmd_t                  cmd,
    input  logic [((NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1)-1:0] idx,
    input  logic [kdef_pkg::TICKS_W-1:0]          load_value,
    output logic                                  fire
);

    logic [kdef_pkg::TICKS_W-1:0] count_reg [NUM_KEYS];
    logic [NUM_KEYS-1:0]          armed_reg;
    logic [kdef_pkg::TICKS_W-1:0] cur_count;
    logic                         expire;

    // Shared unit: compare the selected countdown against one.
    assign cur_count = count_reg[idx];
    assign expire    = (cur_count <= kdef_pkg::TICKS_W'(1));
    assign fire      = cmd.step && armed_reg[idx] && expire;

    // Load on an edge, count down or expire on a scan step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= '0;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (cmd.load)
        begin
            count_reg[idx] <= load_value;
            armed_reg[idx] <= 1'b1;
        end
        else if (cmd.step && armed_reg[idx])
        begin
            if (expire)
            begin
                count_reg[idx] <= '0;
                armed_reg[idx] <= 1'b0;
            end
            else
            begin
                count_reg[idx] <= cur_count - kdef_pkg::TICKS_W'(1);
            end
        end
    end

endmodule

// ----- rtl/core/kdef_checker.sv -----
// ----------------------------------------------------------------------------
// kdef_checker
// Port-level checks of the key debounce and event FIFO block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kdef_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       read_valid,
    input  logic [kdef_pkg::KEY_W-1:0] read_key,
    input  logic                       read_level
);

    // A result that is not taken stays offered.
    `ASSERT_CLKD(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

    // A stalled result keeps its payload.
    `ASSERT_CLKD(a_out_stable, out_valid && !out_ready |=> $stable(read_valid) && $stable(read_key) && $stable(read_level), "stalled result changed")

    // A result without a popped event carries zero key and level.
    `ASSERT_CLKD(a_zero_fields, out_valid && !read_valid |-> read_key == '0 && !read_level, "fields set without an event")

    // The block works on one request at a time.
    `ASSERT_CLKD(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "request accepted while busy")

endmodule

bind key_debounce_event_fifo_core kdef_checker u_kdef_checker (.*);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for key_debounce_event_fifo_core. A predictor class
// follows the per-key countdowns and the event queue, queues one expected
// result per accepted request and compares every returned result field by
// field. Requests come in bursts with random gaps while the result side
// stalls on a pattern of its own. The run includes one long hold-off of the
// result side and several debounce settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb;

    localparam int KEY_W          = kdef_pkg::KEY_W;
    localparam int LEVELS_W       = kdef_pkg::LEVELS_W;
    localparam int TICKS_W        = kdef_pkg::TICKS_W;
    localparam int EVENT_W        = kdef_pkg::EVENT_W;
    localparam int NUM_KEYS       = 8;
    localparam int FIFO_DEPTH     = 128;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 150;
    localparam int DRAIN_CYCLES   = NUM_KEYS + 4;
    localparam logic [1:0] OP_NONE = 2'd3;

    // One result as the block reports it.
    typedef struct packed {
        logic               read_valid;
        logic [KEY_W-1:0]   read_key;
        logic               read_level;
        logic               fifo_empty;
    } key_result_t;

    // Predictor: debounce countdowns, event queue and expected results.
    class key_event_model;
        logic [TICKS_W-1:0] delay;
        logic [TICKS_W-1:0] countdown [NUM_KEYS];
        bit                 armed [NUM_KEYS];
        logic [EVENT_W-1:0] events [$];
        key_result_t        expected_results [$];
        int errors, checked, pushed, dropped, peak;
        int ticks, edges, reads, unused, empty_reads;

        function new();
            delay = kdef_pkg::DEBOUNCE_RESET;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                countdown[k] = '0;
                armed[k] = 1'b0;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        // One slot of the ring always stays free, so a push into a queue
        // holding FIFO_DEPTH - 1 events is lost.
        function void push_event(logic [EVENT_W-1:0] ev);
            if (events.size() >= FIFO_DEPTH - 1)
            begin
                dropped++;
            end
            else
            begin
                events.push_back(ev);
                pushed++;
                if (events.size() > peak)
                    peak = events.size();
            end
        endfunction

        // Apply one accepted request and queue the result it must produce.
        function void note_request(logic [1:0] op, logic [KEY_W-1:0] key,
                                   logic [LEVELS_W-1:0] levels);
            key_result_t        res;
            logic [EVENT_W-1:0] ev;
            res = '0;
            case (op)
                kdef_pkg::OP_TICK:
                begin
                    ticks++;
                    // Keys expire in ascending order within one tick.
                    for (int k = 0; k < NUM_KEYS; k++)
                    begin
                        if (armed[k])
                        begin
                            if (countdown[k] <= 1)
                            begin
                                armed[k] = 1'b0;
                                countdown[k] = '0;
                                push_event({3'(k), levels[k]});
                            end
                            else
                            begin
                                countdown[k] = countdown[k] - 1'b1;
                            end
                        end
                    end
                end
                kdef_pkg::OP_EDGE:
                begin
                    edges++;
                    countdown[key] = delay;
                    armed[key] = 1'b1;
                end
                kdef_pkg::OP_READ:
                begin
                    reads++;
                    if (events.size() != 0)
                    begin
                        ev = events.pop_front();
                        res.read_valid = 1'b1;
                        res.read_key = ev[3:1];
                        res.read_level = ev[0];
                    end
                    else
                    begin
                        empty_reads++;
                    end
                end
                default:
                begin
                    unused++;
                end
            endcase
            res.fifo_empty = (events.size() == 0);
            expected_results.push_back(res);
        endfunction

        // Compare one returned result with the oldest expectation.
        task check_result(key_result_t got);
            key_result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result returned with no request outstanding");
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (got.read_valid !== want.read_valid)
                report_mismatch($sformatf("result %0d read_valid %b, want %b",
                                          checked, got.read_valid, want.read_valid));
            if (got.read_key !== want.read_key)
                report_mismatch($sformatf("result %0d read_key %0d, want %0d",
                                          checked, got.read_key, want.read_key));
            if (got.read_level !== want.read_level)
                report_mismatch($sformatf("result %0d read_level %b, want %b",
                                          checked, got.read_level, want.read_level));
            if (got.fifo_empty !== want.fifo_empty)
                report_mismatch($sformatf("result %0d fifo_empty %b, want %b",
                                          checked, got.fifo_empty, want.fifo_empty));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [1:0]           operation = kdef_pkg::OP_TICK;
    logic [KEY_W-1:0]     key_number = '0;
    logic [LEVELS_W-1:0]  key_levels = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 read_valid;
    logic [KEY_W-1:0]     read_key;
    logic                 read_level;
    logic                 fifo_empty;
    logic                 cfg_we = 1'b0;
    logic [TICKS_W-1:0]   cfg_wdata = '0;

    key_event_model model;
    int results_seen = 0;
    int quiet_cycles = 0;
    int burst_left = 0;
    int cfg_writes = 0;

    key_debounce_event_fifo_core #(
        .NUM_KEYS   (NUM_KEYS),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .key_number (key_number),
        .key_levels (key_levels),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_valid (read_valid),
        .read_key   (read_key),
        .read_level (read_level),
        .fifo_empty (fifo_empty),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Monitors on both channels, plus the watchdog on handshake activity.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                model.note_request(operation, key_number, key_levels);
            if (out_valid && out_ready)
            begin
                model.check_result({read_valid, read_key, read_level, fifo_empty});
                results_seen++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles", quiet_cycles);
                $display("FAIL key_debounce_event_fifo_core");
                $finish;
            end
        end
    end

    // Result side: stall patterns that change at random intervals, and one
    // long hold-off so that the block backs up into its request side.
    initial
    begin
        int  mode;
        int  span;
        int  hold_left;
        int  beat;
        bit  held;
        mode = 0;
        span = 0;
        hold_left = 0;
        beat = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (span == 0)
            begin
                mode = $urandom_range(3);
                span = $urandom_range(80, 16);
            end
            span--;
            beat = (beat + 1) % 4;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(99) < 70);
                    2: out_ready <= (beat == 0);
                    default: out_ready <= ($urandom_range(99) < 25);
                endcase
            end
        end
    end

    // Sender pacing: bursts of random length separated by random gaps.
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(30, 1);
            gap = ($urandom_range(99) < 30) ? 0 : $urandom_range(10, 1);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Offer one request and hold it until it is accepted.
    task automatic send_request(logic [1:0] op, logic [KEY_W-1:0] key,
                                logic [LEVELS_W-1:0] levels);
        pace();
        in_valid   <= 1'b1;
        operation  <= op;
        key_number <= key;
        key_levels <= levels;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // Let every outstanding request return its result.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (model.pending() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_delay(logic [TICKS_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        model.delay = value;
        cfg_writes++;
    endtask

    // Random mix of requests; percentages for read, edge and tick, the rest
    // being the unused code.
    task automatic send_mix(int count, int read_pct, int edge_pct, int tick_pct);
        int roll;
        logic [1:0] op;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < read_pct)
                op = kdef_pkg::OP_READ;
            else if (roll < read_pct + edge_pct)
                op = kdef_pkg::OP_EDGE;
            else if (roll < read_pct + edge_pct + tick_pct)
                op = kdef_pkg::OP_TICK;
            else
                op = OP_NONE;
            send_request(op, KEY_W'($urandom_range(7)), LEVELS_W'($urandom_range(255)));
        end
    endtask

    // Edges on every key in random order, sometimes one repeated, then enough
    // ticks for all of them to expire together.
    task automatic send_key_sweep();
        int order [NUM_KEYS];
        int j;
        int tmp;
        int need;
        for (int k = 0; k < NUM_KEYS; k++)
            order[k] = k;
        for (int k = NUM_KEYS - 1; k > 0; k--)
        begin
            j = $urandom_range(k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < NUM_KEYS; k++)
            send_request(kdef_pkg::OP_EDGE, KEY_W'(order[k]),
                         LEVELS_W'($urandom_range(255)));
        if ($urandom_range(3) == 0)
            send_request(kdef_pkg::OP_EDGE, KEY_W'(order[0]),
                         LEVELS_W'($urandom_range(255)));
        need = (model.delay == 0) ? 1 : int'(model.delay);
        for (int t = 0; t < need; t++)
            send_request(kdef_pkg::OP_TICK, KEY_W'($urandom_range(7)),
                         LEVELS_W'($urandom_range(255)));
    endtask

    // Main sequence.
    initial
    begin
        model = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset delay: read from an empty queue, unused code, a long countdown.
        send_request(kdef_pkg::OP_READ, 3'd7, 8'hFF);
        send_request(OP_NONE, 3'd7, 8'hFF);
        send_request(OP_NONE, 3'd0, 8'h00);
        send_request(kdef_pkg::OP_EDGE, 3'd2, 8'h00);
        send_request(kdef_pkg::OP_TICK, 3'd0, 8'h00);

        // Zero delay fires on the next tick; three keys expire in key order,
        // one of them edged twice.
        write_delay(10'd0);
        send_request(kdef_pkg::OP_EDGE, 3'd7, 8'h00);
        send_request(kdef_pkg::OP_EDGE, 3'd0, 8'h00);
        send_request(kdef_pkg::OP_EDGE, 3'd3, 8'hFF);
        send_request(kdef_pkg::OP_EDGE, 3'd3, 8'h00);
        send_request(kdef_pkg::OP_TICK, 3'd5, 8'h81);
        repeat (4) send_request(kdef_pkg::OP_READ, 3'd0, 8'h00);
        send_request(kdef_pkg::OP_TICK, 3'd0, 8'hFF);

        // Another edge while armed restarts the countdown.
        write_delay(10'd2);
        send_request(kdef_pkg::OP_EDGE, 3'd4, 8'h00);
        send_request(kdef_pkg::OP_TICK, 3'd0, 8'hFF);
        send_request(kdef_pkg::OP_EDGE, 3'd4, 8'h00);
        send_request(kdef_pkg::OP_TICK, 3'd0, 8'h00);
        send_request(kdef_pkg::OP_TICK, 3'd0, 8'h10);
        send_request(kdef_pkg::OP_READ, 3'd0, 8'h00);
        send_request(kdef_pkg::OP_READ, 3'd0, 8'h00);

        // Fill the queue past full with sweeps over all keys.
        write_delay(10'd1);
        for (int s = 0; s < 18; s++)
        begin
            send_key_sweep();
            send_mix($urandom_range(2), 30, 30, 30);
        end

        // Drain with a read-heavy mix.
        write_delay(10'd3);
        send_mix(180, 50, 20, 25);

        // Longest delay: countdowns load the full width and keep counting.
        write_delay(10'd1023);
        send_mix(40, 30, 30, 35);

        // A short random delay, balanced traffic with occasional sweeps.
        write_delay(TICKS_W'($urandom_range(6, 1)));
        for (int s = 0; s < 5; s++)
        begin
            send_mix(40, 30, 30, 35);
            send_key_sweep();
        end

        write_delay(10'd0);
        for (int s = 0; s < 8; s++)
            send_key_sweep();
        send_mix(60, 40, 25, 30);

        write_delay(10'd2);
        send_mix(120, 55, 20, 20);

        // Let the last results return and watch for stray ones.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (model.pending() != 0)
            model.report_mismatch($sformatf("%0d results never returned", model.pending()));

        $display("Covered %0d ticks, %0d edges, %0d reads (%0d on empty), %0d unused codes;",
                 model.ticks, model.edges, model.reads, model.empty_reads, model.unused);
        $display("%0d results checked, %0d events queued, %0d lost on full,",
                 model.checked, model.pushed, model.dropped);
        $display("peak queue depth %0d, %0d delay writes.", model.peak, cfg_writes);
        if (model.errors == 0)
            $display("PASS key_debounce_event_fifo_core");
        else
            $display("FAIL key_debounce_event_fifo_core");
        $finish;
    end

endmodule
